// ----- src/wcs_pkg.sv -----
// shared types, register indexes and constants for the wireless charge supervisor
package wcs_pkg;

    localparam int AddrWidth   = 5;
    localparam int DataWidth   = 32;
    localparam int InWidth     = 40;
    localparam int OutWidth    = 8;

    // hysteresis on the thermal exits, in degrees
    localparam int HysHot      = 5;
    localparam int HysCold     = 2;

    // register reset values
    localparam logic       ResetWiredPrio = 1'b1;
    localparam logic [6:0] ResetResumePct = 7'd99;
    localparam logic [15:0] ResetResumeVolt = 16'd0;
    localparam logic signed [7:0] ResetHotLimit  = 8'sd60;
    localparam logic signed [7:0] ResetColdLimit = -8'sd20;

    // divide by ten through a reciprocal: x * 6554 >> 16 is exact for |x| <= 2048
    localparam logic [12:0] DivRecip = 13'd6554;
    localparam int DivShift = 16;

    typedef enum logic [2:0] {
        REG_WIRED_PRIO  = 3'd0,
        REG_RESUME_PCT  = 3'd1,
        REG_RESUME_VOLT = 3'd2,
        REG_HOT_LIMIT   = 3'd3,
        REG_COLD_LIMIT  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_WAIT  = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_HOT   = 3'd2,
        MODE_COLD  = 3'd3,
        MODE_DONE  = 3'd4,
        MODE_WIRED = 3'd5
    } mode_t;

    typedef struct packed {
        logic              wired_has_priority;
        logic [6:0]        resume_percent;
        logic [15:0]       resume_voltage;
        logic signed [7:0] hot_limit;
        logic signed [7:0] cold_limit;
    } cfg_t;

    // lowest field last, so the packed word matches tdata/tuser order
    typedef struct packed {
        logic               pad_detect_n;
        logic               taper_hit;
        logic [6:0]         charge_percent;
        logic [15:0]        battery_voltage;
        logic signed [11:0] temp_tenths;
        logic               wired_present;
        logic               wireless_powered;
        logic               sample_valid;
    } sample_t;

    typedef struct packed {
        logic  online;
        logic  pad_present;
        logic  shutdown_latched;
        logic  terminate_level;
        logic  complete_n_level;
        mode_t mode;
    } result_t;

    typedef struct packed {
        mode_t mode;
        logic  complete_pin;
        logic  terminate_pin;
        logic  shutdown;
    } fsm_state_t;

endpackage

// ----- src/wcs_cfg_regs.sv -----
// apb register file holding the supervisor configuration
module wcs_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wcs_pkg::AddrWidth-1:0]   paddr,
    input  logic [wcs_pkg::DataWidth-1:0]   pwdata,
    output logic [wcs_pkg::DataWidth-1:0]   prdata,
    output logic                            pready,
    output wcs_pkg::cfg_t                   cfg
);
    import wcs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_WIRED_PRIO:  cfg_next.wired_has_priority = pwdata[0];
                REG_RESUME_PCT:  cfg_next.resume_percent = pwdata[6:0];
                REG_RESUME_VOLT: cfg_next.resume_voltage = pwdata[15:0];
                REG_HOT_LIMIT:   cfg_next.hot_limit = pwdata[7:0];
                REG_COLD_LIMIT:  cfg_next.cold_limit = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wired_has_priority <= ResetWiredPrio;
            cfg_reg.resume_percent     <= ResetResumePct;
            cfg_reg.resume_voltage     <= ResetResumeVolt;
            cfg_reg.hot_limit          <= ResetHotLimit;
            cfg_reg.cold_limit         <= ResetColdLimit;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_WIRED_PRIO:  prdata[0]    = cfg_reg.wired_has_priority;
            REG_RESUME_PCT:  prdata[6:0]  = cfg_reg.resume_percent;
            REG_RESUME_VOLT: prdata[15:0] = cfg_reg.resume_voltage;
            REG_HOT_LIMIT:   prdata = DataWidth'(cfg_reg.hot_limit);
            REG_COLD_LIMIT:  prdata = DataWidth'(cfg_reg.cold_limit);
            default: ;
        endcase
    end

endmodule

// ----- src/wcs_temp_div.sv -----
// tenths of a degree to whole degrees, truncating toward zero
module wcs_temp_div
(
    input  logic signed [11:0] temp_tenths,
    output logic signed [8:0]  deg
);
    import wcs_pkg::*;

    logic        neg;
    logic [11:0] mag;
    logic [24:0] prod;
    logic [8:0]  quo;

    assign neg  = temp_tenths[11];
    // -2048 maps to 2048, which still fits 12 unsigned bits
    assign mag  = neg ? 12'(-temp_tenths) : 12'(temp_tenths);
    assign prod = 25'(mag) * 25'(DivRecip);
    assign quo  = prod[DivShift +: 9];
    assign deg  = neg ? 9'(-quo) : quo;

endmodule

// ----- src/wcs_mode_fsm.sv -----
// charge mode state machine, pin levels and shutdown latch
module wcs_mode_fsm
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  wcs_pkg::sample_t       smp,
    input  logic signed [8:0]      deg,
    input  wcs_pkg::cfg_t          cfg,
    output wcs_pkg::result_t       res,
    output wcs_pkg::fsm_state_t    st
);
    import wcs_pkg::*;

    fsm_state_t        st_reg;
    fsm_state_t        st_next;
    logic signed [9:0] deg_w;
    logic signed [9:0] hot_w;
    logic signed [9:0] cold_w;
    logic signed [9:0] hot_exit;
    logic signed [9:0] cold_exit;
    logic              preempt;

    assign deg_w     = {deg[8], deg};
    assign hot_w     = {{2{cfg.hot_limit[7]}}, cfg.hot_limit};
    assign cold_w    = {{2{cfg.cold_limit[7]}}, cfg.cold_limit};
    assign hot_exit  = hot_w - 10'(HysHot);
    assign cold_exit = cold_w + 10'(HysCold);
    assign preempt   = smp.wired_present && cfg.wired_has_priority;
    assign st        = st_reg;

    // next state
    always_comb
    begin
        st_next = st_reg;
        if (smp.sample_valid)
        begin
            if (smp.charge_percent == 7'd0)
                st_next.shutdown = 1'b1;
            if (st_reg.mode == MODE_WIRED)
            begin
                if (!smp.wired_present)
                begin
                    st_next.complete_pin = 1'b1;
                    st_next.mode         = MODE_WAIT;
                end
            end
            else if (preempt)
            begin
                st_next.complete_pin = 1'b0;
                st_next.mode         = MODE_WIRED;
            end
            else
            begin
                unique case (st_reg.mode)
                    MODE_WAIT:
                    begin
                        if (smp.wireless_powered)
                            st_next.mode = MODE_RUN;
                    end
                    MODE_RUN:
                    begin
                        priority if (!smp.wireless_powered)
                        begin
                            st_next.complete_pin  = 1'b1;
                            st_next.terminate_pin = 1'b0;
                            st_next.mode          = MODE_WAIT;
                        end
                        else if (deg_w >= hot_w)
                        begin
                            st_next.terminate_pin = 1'b1;
                            st_next.mode          = MODE_HOT;
                        end
                        else if (deg_w <= cold_w)
                        begin
                            st_next.terminate_pin = 1'b1;
                            st_next.mode          = MODE_COLD;
                        end
                        else if (smp.taper_hit)
                        begin
                            st_next.complete_pin = 1'b0;
                            st_next.mode         = MODE_DONE;
                        end
                    end
                    MODE_HOT:
                    begin
                        if (deg_w < hot_exit)
                        begin
                            st_next.complete_pin  = 1'b1;
                            st_next.terminate_pin = 1'b0;
                            st_next.mode          = MODE_WAIT;
                        end
                    end
                    MODE_COLD:
                    begin
                        if (deg_w > cold_exit)
                        begin
                            st_next.complete_pin  = 1'b1;
                            st_next.terminate_pin = 1'b0;
                            st_next.mode          = MODE_WAIT;
                        end
                    end
                    MODE_DONE:
                    begin
                        if (smp.charge_percent <= cfg.resume_percent ||
                            smp.battery_voltage <= cfg.resume_voltage)
                        begin
                            st_next.complete_pin  = 1'b1;
                            st_next.terminate_pin = 1'b0;
                            st_next.mode          = MODE_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result word, reflecting the state after this sample
    always_comb
    begin
        res.mode             = st_next.mode;
        res.complete_n_level = st_next.complete_pin;
        res.terminate_level  = st_next.terminate_pin;
        res.shutdown_latched = st_next.shutdown;
        res.pad_present      = !smp.pad_detect_n && !st_next.shutdown;
        res.online           = smp.sample_valid && smp.wireless_powered &&
                               !st_next.shutdown;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode          <= MODE_WAIT;
            st_reg.complete_pin  <= 1'b1;
            st_reg.terminate_pin <= 1'b0;
            st_reg.shutdown      <= 1'b0;
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ----- src/wireless_charge_supervisor.sv -----
// top level: stream pipeline around the wireless charge supervisor
// One poll word in, one status word out. A word is captured in the input register,
// goes through the temperature scaling and the mode state machine, and lands in the
// output register when that register is empty or being drained, and its result is
// offered on the output from there. One word per cycle is taken as long as results are
// drained; the mode state is updated once per word, in acceptance order, by the single
// state machine. The input side stalls only when both the input and output registers
// are full and the output is held off.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16
// and should be written only while no word is in flight.
module wireless_charge_supervisor
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // wireless_powered, wired_present, temp_tenths, battery_voltage, charge_percent,
    // taper_hit, pad_detect_n, zero pad
    input  logic [wcs_pkg::InWidth-1:0]     s_tdata,
    // sample_valid
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mode, complete_n_level, terminate_level, shutdown_latched, pad_present, online
    output logic [wcs_pkg::OutWidth-1:0]    m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wcs_pkg::AddrWidth-1:0]   paddr,
    input  logic [wcs_pkg::DataWidth-1:0]   pwdata,
    output logic [wcs_pkg::DataWidth-1:0]   prdata,
    output logic                            pready
);
    import wcs_pkg::*;

    cfg_t              cfg;
    sample_t           in_reg;
    logic              in_vld_reg;
    logic              in_vld_next;
    result_t           out_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    result_t           res;
    fsm_state_t        st;
    logic signed [8:0] deg;
    logic              step;
    logic              take;

    wcs_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wcs_temp_div u_div
    (
        .temp_tenths (in_reg.temp_tenths),
        .deg         (deg)
    );

    wcs_mode_fsm u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .smp   (in_reg),
        .deg   (deg),
        .cfg   (cfg),
        .res   (res),
        .st    (st)
    );

    // word moves from input register to output register
    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        priority if (take)
            in_vld_next = 1'b1;
        else if (step)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        priority if (step)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= {s_tdata[InWidth-2:0], s_tuser};
        if (step)
            out_reg <= res;
    end

`ifndef SYNTHESIS
    // shutdown latch never clears
    assert property (@(posedge clk) disable iff (!rst_n)
        st.shutdown |=> st.shutdown)
        else $error("shutdown latch cleared");

    // wired mode always holds the complete pin low
    assert property (@(posedge clk) disable iff (!rst_n)
        st.mode == MODE_WIRED |-> !st.complete_pin)
        else $error("complete pin high in wired mode");

    // waiting or running always has the complete pin released
    assert property (@(posedge clk) disable iff (!rst_n)
        (st.mode == MODE_WAIT || st.mode == MODE_RUN) |-> st.complete_pin)
        else $error("complete pin low while waiting or running");

    // state only moves when a word passes through
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(st))
        else $error("state changed without a word");
`endif

endmodule
